[src/bdq_pkg.sv]
// shared constants, types and index helpers for the bounded deque engine
`default_nettype none

package bdq_pkg;

    // store geometry
    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;

    // field widths
    localparam int WORD_W = 32;
    localparam int KIND_W = 3;
    localparam int CAP_W  = 5;
    localparam int OCC_W  = 5;
    localparam int STAT_W = 2;
    localparam int APB_AW = 2;
    localparam int APB_DW = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // register byte addresses
    localparam logic [APB_AW-1:0] REG_CAPACITY = '0;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_DONE       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL       = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY      = 2'd2;

    // store access request from the controller
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr_front;
        logic [ADDR_W-1:0] raddr_back;
    } t_ram_req;

    // head plus offset, circular over the store depth
    function automatic logic [ADDR_W-1:0] wrap_sum(input logic [ADDR_W-1:0] head,
                                                   input logic [CNT_W-1:0]  off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(head) + SUM_W'(off);
        if (s >= SUM_W'(DEPTH)) begin
            s = s - SUM_W'(DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

    // head minus one, circular
    function automatic logic [ADDR_W-1:0] wrap_dec(input logic [ADDR_W-1:0] head);
        logic [ADDR_W-1:0] r;
        if (head == '0) begin
            r = ADDR_W'(DEPTH - 1);
        end else begin
            r = head - ADDR_W'(1);
        end
        return r;
    endfunction

    // head plus one, circular
    function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] head);
        logic [ADDR_W-1:0] r;
        if (head == ADDR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = head + ADDR_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/bdq_ram.sv]
// generic word store: one write port, two registered read ports
`default_nettype none

module bdq_ram #(
    parameter int P_DATA_W = 32,
    parameter int P_DEPTH  = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  wire logic [P_DATA_W-1:0]        i_wdata,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_raddr_a,
    output      logic [P_DATA_W-1:0]        o_rdata_a,
    input  wire logic [$clog2(P_DEPTH)-1:0] i_raddr_b,
    output      logic [P_DATA_W-1:0]        o_rdata_b
);

    logic [P_DATA_W-1:0] mem [P_DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, registered
    always_ff @(posedge i_clk) begin
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

`default_nettype wire

[src/bdq_cfg.sv]
// capacity register behind the apb port
`default_nettype none

module bdq_cfg
    import bdq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output      logic [APB_DW-1:0] prdata,
    output      logic              pready,
    output      logic [CAP_W-1:0]  o_cap
);

    logic [CAP_W-1:0] r_cap;
    logic             wr_hit;

    // single register at byte address zero
    assign wr_hit = psel && penable && pwrite && (paddr == REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (wr_hit) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    // read back and handshake
    assign prdata = APB_DW'(r_cap);
    assign pready = 1'b1;
    assign o_cap  = r_cap;

endmodule

`default_nettype wire

[src/bdq_ctrl.sv]
// operation sequencer: pointer update, store access and result register
`default_nettype none

module bdq_ctrl
    import bdq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [CAP_W-1:0]  i_cap,
    input  wire logic              i_in_valid,
    output      logic              o_in_stall,
    input  wire logic [KIND_W-1:0] i_kind,
    input  wire logic [WORD_W-1:0] i_value,
    output      t_ram_req          o_ram,
    input  wire logic [WORD_W-1:0] i_rd_front,
    input  wire logic [WORD_W-1:0] i_rd_back,
    output      logic              o_out_valid,
    input  wire logic              i_out_stall,
    output      logic [WORD_W-1:0] o_front_value,
    output      logic [WORD_W-1:0] o_back_value,
    output      logic [OCC_W-1:0]  o_occupancy,
    output      logic              o_is_empty,
    output      logic [STAT_W-1:0] o_status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [STAT_W-1:0] r_stat, n_stat;

    logic              r_out_valid;
    logic [WORD_W-1:0] r_front, r_back;
    logic [OCC_W-1:0]  r_occ;
    logic              r_empty;
    logic [STAT_W-1:0] r_ostat;

    logic [CNT_W-1:0]  limit;
    logic              accept;
    logic              full;
    logic              load;
    logic              we;
    logic [ADDR_W-1:0] waddr;

    // effective capacity, clamped to one..depth
    always_comb begin
        if (i_cap == '0) begin
            limit = CNT_W'(1);
        end else if (32'(i_cap) > 32'(DEPTH)) begin
            limit = CNT_W'(DEPTH);
        end else begin
            limit = CNT_W'(i_cap);
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign full       = (r_count >= limit);

    // operation decode and pointer update
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_stat  = STAT_DONE;
        we      = 1'b0;
        waddr   = wrap_sum(r_head, r_count);
        unique case (i_kind)
            KIND_PUSH_FRONT: begin
                if (full) begin
                    n_stat = STAT_FULL;
                end else begin
                    n_head  = wrap_dec(r_head);
                    waddr   = wrap_dec(r_head);
                    we      = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            KIND_PUSH_BACK: begin
                if (full) begin
                    n_stat = STAT_FULL;
                end else begin
                    we      = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            KIND_POP_FRONT: begin
                if (r_count == '0) begin
                    n_stat = STAT_EMPTY;
                end else begin
                    n_head  = wrap_inc(r_head);
                    n_count = r_count - CNT_W'(1);
                end
            end
            KIND_POP_BACK: begin
                if (r_count == '0) begin
                    n_stat = STAT_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                // query and unused codes leave everything as is
            end
        endcase
    end

    // store access: write at accept, read ends from the updated pointers
    always_comb begin
        o_ram.we          = accept && we;
        o_ram.waddr       = waddr;
        o_ram.wdata       = i_value;
        o_ram.raddr_front = r_head;
        if (r_count == '0) begin
            o_ram.raddr_back = r_head;
        end else begin
            o_ram.raddr_back = wrap_sum(r_head, r_count - CNT_W'(1));
        end
    end

    assign load = (r_state == ST_LOAD) && (!r_out_valid || !i_out_stall);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept) n_state = ST_READ;
            ST_READ: n_state = ST_LOAD;
            ST_LOAD: if (load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stat <= n_stat;
        end
    end

    // result register, holds while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_front <= (r_count == '0) ? '0 : i_rd_front;
            r_back  <= (r_count == '0) ? '0 : i_rd_back;
            r_occ   <= OCC_W'(r_count);
            r_empty <= (r_count == '0);
            r_ostat <= r_stat;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_front_value = r_front;
    assign o_back_value  = r_back;
    assign o_occupancy   = r_occ;
    assign o_is_empty    = r_empty;
    assign o_status      = r_ostat;

endmodule

`default_nettype wire

[src/bounded_deque_engine.sv]
// Bounded double-ended queue of signed 32-bit words in a circular store.
//
// Input channel: i_in_valid / o_in_stall with i_kind and i_value. A transaction
// is taken at a rising edge with i_in_valid high and o_in_stall low. Kinds:
// push front, push back, pop front, pop back, query; unused codes query.
// Output channel: o_out_valid / i_out_stall, one result per input
// transaction: front and back words (0 when empty), occupancy, empty flag
// and status (done, push rejected full, pop rejected empty).
// Capacity register at byte address 0 of the apb port, reset 16; values of
// 0 act as 1 and values above the store depth act as the depth.
//
// The result register loads once the sequencer has stepped through its read
// and load states, and no new transaction is taken until it is idle again.
// The sequence is pointer update plus store write, then a read of both ends
// through the registered store read ports, then the result load.
// When the receiver stalls, the finished result waits in the output register
// and the next transaction is accepted and worked; a second result waits in
// the sequencer until the register frees.
// Reset (synchronous, active low) empties the deque, sets the capacity to 16
// and drops o_out_valid. The store itself is not cleared.
`default_nettype none

module bounded_deque_engine
    import bdq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output      logic [APB_DW-1:0] prdata,
    output      logic              pready,
    input  wire logic              i_in_valid,
    output      logic              o_in_stall,
    input  wire logic [KIND_W-1:0] i_kind,
    input  wire logic [WORD_W-1:0] i_value,
    output      logic              o_out_valid,
    input  wire logic              i_out_stall,
    output      logic [WORD_W-1:0] o_front_value,
    output      logic [WORD_W-1:0] o_back_value,
    output      logic [OCC_W-1:0]  o_occupancy,
    output      logic              o_is_empty,
    output      logic [STAT_W-1:0] o_status
);

    logic [CAP_W-1:0]  cap;
    t_ram_req          ram_req;
    logic [WORD_W-1:0] rd_front, rd_back;

    // configuration register
    bdq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cap   (cap)
    );

    // sequencer and result register
    bdq_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cap         (cap),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .o_ram         (ram_req),
        .i_rd_front    (rd_front),
        .i_rd_back     (rd_back),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value),
        .o_occupancy   (o_occupancy),
        .o_is_empty    (o_is_empty),
        .o_status      (o_status)
    );

    // word store
    bdq_ram #(
        .P_DATA_W (WORD_W),
        .P_DEPTH  (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_req.we),
        .i_waddr   (ram_req.waddr),
        .i_wdata   (ram_req.wdata),
        .i_raddr_a (ram_req.raddr_front),
        .o_rdata_a (rd_front),
        .i_raddr_b (ram_req.raddr_back),
        .o_rdata_b (rd_back)
    );

endmodule

`default_nettype wire

[src/bdq_checker.sv]
// port-level checks for the bounded deque engine, bound to the top level
`default_nettype none

module bdq_checker
    import bdq_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic [WORD_W-1:0] o_front_value,
    input wire logic [WORD_W-1:0] o_back_value,
    input wire logic [OCC_W-1:0]  o_occupancy,
    input wire logic              o_is_empty,
    input wire logic [STAT_W-1:0] o_status
);

    // reset drops the result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_front_value)
            && $stable(o_back_value) && $stable(o_occupancy) && $stable(o_status))
        else $error("stalled result changed");

    // empty flag agrees with occupancy
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_occupancy == '0)))
        else $error("empty flag and occupancy disagree");

    // an empty deque reads zero at both ends
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_empty |-> (o_front_value == '0) && (o_back_value == '0))
        else $error("nonzero ends on empty deque");

    // a rejected pop only happens on an empty deque
    a_pop_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STAT_EMPTY) |-> o_is_empty)
        else $error("pop rejected on nonempty deque");

endmodule

bind bounded_deque_engine bdq_checker u_bdq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_front_value (o_front_value),
    .o_back_value  (o_back_value),
    .o_occupancy   (o_occupancy),
    .o_is_empty    (o_is_empty),
    .o_status      (o_status)
);

`default_nettype wire

[tb/tb_top.sv]
// self-checking testbench for the bounded deque engine: random and directed deque traffic
`timescale 1ns / 1ps

module tb_top;
    import bdq_pkg::*;

    // register address and spare operation codes that act as a query
    localparam logic [APB_AW-1:0] CAPACITY_ADDR = REG_CAPACITY;
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = KIND_QUERY + KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_LAST     = '1;
    localparam int                HOLD_CYCLES   = 200;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] word;
    } t_deque_op;

    typedef struct packed {
        logic [WORD_W-1:0] front;
        logic [WORD_W-1:0] back;
        logic [OCC_W-1:0]  occ;
        logic              empty;
        logic [STAT_W-1:0] status;
    } t_deque_view;

    // clock, reset and block inputs, all known from time zero
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr       = '0;
    logic [APB_DW-1:0] pwdata      = '0;
    logic              i_in_valid  = 1'b0;
    logic [KIND_W-1:0] i_kind      = '0;
    logic [WORD_W-1:0] i_value     = '0;
    logic              i_out_stall = 1'b0;

    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [WORD_W-1:0] o_front_value;
    logic [WORD_W-1:0] o_back_value;
    logic [OCC_W-1:0]  o_occupancy;
    logic              o_is_empty;
    logic [STAT_W-1:0] o_status;

    // traffic control
    t_deque_op   op_backlog[$];
    t_deque_view deque_views[$];
    int          queued_items   = 0;
    int          accepted_items = 0;
    int          failures       = 0;
    int          snd_pct        = 0;
    int          rcv_pct        = 0;
    logic        hold_req       = 1'b0;
    logic        hold_on        = 1'b0;

    // shadow deque state
    logic [WORD_W-1:0] word_copy[DEPTH];
    logic [ADDR_W-1:0] head_copy  = '0;
    logic [CNT_W-1:0]  count_copy = '0;
    logic [CAP_W-1:0]  cap_copy   = CAP_RESET;

    bounded_deque_engine u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value),
        .o_occupancy   (o_occupancy),
        .o_is_empty    (o_is_empty),
        .o_status      (o_status)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // apply one operation to the shadow deque and return the view it leaves
    function automatic t_deque_view deque_apply(input logic [KIND_W-1:0] kind,
                                                input logic [WORD_W-1:0] word);
        t_deque_view view;
        int          lim;
        lim = int'(cap_copy);
        if (lim < 1) lim = 1;
        if (lim > DEPTH) lim = DEPTH;
        view.status = STAT_DONE;
        case (kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                if (int'(count_copy) >= lim) begin
                    view.status = STAT_FULL;
                end else if (kind == KIND_PUSH_FRONT) begin
                    head_copy = ADDR_W'((int'(head_copy) + DEPTH - 1) % DEPTH);
                    word_copy[head_copy] = word;
                    count_copy = count_copy + CNT_W'(1);
                end else begin
                    word_copy[ADDR_W'((int'(head_copy) + int'(count_copy)) % DEPTH)] = word;
                    count_copy = count_copy + CNT_W'(1);
                end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
                if (count_copy == '0) begin
                    view.status = STAT_EMPTY;
                end else begin
                    if (kind == KIND_POP_FRONT) begin
                        head_copy = ADDR_W'((int'(head_copy) + 1) % DEPTH);
                    end
                    count_copy = count_copy - CNT_W'(1);
                end
            end
            default: ;
        endcase
        // peek both ends, zero when empty
        if (count_copy != '0) begin
            view.front = word_copy[head_copy];
            view.back  = word_copy[ADDR_W'((int'(head_copy) + int'(count_copy) - 1) % DEPTH)];
        end else begin
            view.front = '0;
            view.back  = '0;
        end
        view.occ   = OCC_W'(count_copy);
        view.empty = (count_copy == '0);
        return view;
    endfunction

    // input driver: predicts on each accepted transaction, then offers the next
    always @(posedge i_clk) begin : op_driver
        t_deque_op nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                deque_views.push_back(deque_apply(i_kind, i_value));
                accepted_items++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (op_backlog.size() != 0 && $urandom_range(99) >= snd_pct) begin
                    nxt = op_backlog.pop_front();
                    i_in_valid <= 1'b1;
                    i_kind     <= nxt.kind;
                    i_value    <= nxt.word;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compares each accepted result with the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        t_deque_view want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (deque_views.size() == 0) begin
                    $error("result transaction with no operation outstanding");
                    failures++;
                end else begin
                    want = deque_views.pop_front();
                    if (o_front_value !== want.front) begin
                        $error("front_value: expected %0d, got %0d",
                               $signed(want.front), $signed(o_front_value));
                        failures++;
                    end
                    if (o_back_value !== want.back) begin
                        $error("back_value: expected %0d, got %0d",
                               $signed(want.back), $signed(o_back_value));
                        failures++;
                    end
                    if (o_occupancy !== want.occ) begin
                        $error("occupancy: expected %0d, got %0d", want.occ, o_occupancy);
                        failures++;
                    end
                    if (o_is_empty !== want.empty) begin
                        $error("is_empty: expected %0d, got %0d", want.empty, o_is_empty);
                        failures++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        failures++;
                    end
                end
            end
            i_out_stall <= hold_on || ($urandom_range(99) < rcv_pct);
        end
    end

    // long receiver hold-off, counted here
    initial begin : long_hold
        wait (hold_req);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // random word with a bias toward the extremes
    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(7))
            0: return {1'b0, {(WORD_W-1){1'b1}}};
            1: return {1'b1, {(WORD_W-1){1'b0}}};
            2: return '0;
            3: return '1;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    // random operation, push_pct percent pushes
    function automatic t_deque_op rand_op(input int push_pct);
        t_deque_op op;
        int        roll;
        roll    = $urandom_range(99);
        op.word = rand_word();
        if (roll < push_pct) begin
            op.kind = $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        end else if (roll < 92) begin
            op.kind = $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
        end else if (roll < 96) begin
            op.kind = KIND_QUERY;
        end else begin
            op.kind = KIND_W'($urandom_range(KIND_LAST, KIND_SPARE_LO));
        end
        return op;
    endfunction

    task automatic add_op(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] word);
        op_backlog.push_back('{kind: kind, word: word});
        queued_items++;
    endtask

    // bursts that alternate between filling and emptying
    task automatic add_random(input int n);
        int left;
        int burst;
        int bias;
        left = n;
        bias = 80;
        while (left > 0) begin
            burst = $urandom_range(24, 6);
            if (burst > left) burst = left;
            repeat (burst) add_op_struct(rand_op(bias));
            left -= burst;
            bias = (bias > 50) ? 25 : 80;
        end
    endtask

    task automatic add_op_struct(input t_deque_op op);
        op_backlog.push_back(op);
        queued_items++;
    endtask

    task automatic set_idle(input int snd, input int rcv);
        @(posedge i_clk);
        snd_pct <= snd;
        rcv_pct <= rcv;
    endtask

    // wait until every queued operation has come back, plus the pipeline tail
    task automatic drain();
        while (accepted_items != queued_items || deque_views.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // capacity write followed by a read back
    task automatic cfg_write(input logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        cap_copy = data[CAP_W-1:0];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[CAP_W-1:0] !== cap_copy) begin
            $error("capacity: expected %0d, got %0d", cap_copy, prdata[CAP_W-1:0]);
            failures++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // main sequence
    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty deque, extremes, spare codes, draining
        cfg_write(APB_DW'(CAP_RESET));
        add_op(KIND_POP_FRONT, rand_word());
        add_op(KIND_POP_BACK, rand_word());
        add_op(KIND_QUERY, rand_word());
        add_op(KIND_PUSH_FRONT, {1'b0, {(WORD_W-1){1'b1}}});
        add_op(KIND_PUSH_BACK, {1'b1, {(WORD_W-1){1'b0}}});
        add_op(KIND_PUSH_FRONT, '1);
        add_op(KIND_PUSH_BACK, '0);
        add_op(KIND_QUERY, WORD_W'($urandom));
        add_op(KIND_SPARE_LO, WORD_W'($urandom));
        add_op(KIND_LAST, WORD_W'($urandom));
        add_op(KIND_POP_FRONT, WORD_W'($urandom));
        add_op(KIND_POP_BACK, WORD_W'($urandom));
        add_op(KIND_POP_FRONT, WORD_W'($urandom));
        add_op(KIND_POP_BACK, WORD_W'($urandom));
        add_op(KIND_POP_BACK, WORD_W'($urandom));
        drain();

        // smallest capacity: one word, then a full reject
        cfg_write(APB_DW'(1));
        add_op(KIND_PUSH_BACK, rand_word());
        add_op(KIND_PUSH_FRONT, rand_word());
        add_op(KIND_QUERY, rand_word());
        add_op(KIND_POP_FRONT, rand_word());
        add_op(KIND_POP_FRONT, rand_word());
        drain();

        // zero capacity behaves as one
        cfg_write(APB_DW'(0));
        add_op(KIND_PUSH_FRONT, rand_word());
        add_op(KIND_PUSH_BACK, rand_word());
        add_op(KIND_POP_BACK, rand_word());
        drain();

        // random: full capacity, no idling, ending with a fill
        cfg_write(APB_DW'(DEPTH));
        add_random(80);
        repeat (10) add_op(KIND_PUSH_BACK, rand_word());
        drain();

        // capacity lowered below the occupancy, sender mostly idle
        cfg_write(APB_DW'(2));
        set_idle(82, 0);
        add_random(85);
        drain();

        // random capacity, receiver mostly stalled
        cfg_write(APB_DW'($urandom_range(DEPTH, 1)));
        set_idle(0, 82);
        add_random(85);
        drain();

        // over-range capacity with junk in the upper bits, light idling on both
        cfg_write({(APB_DW-CAP_W)'($urandom), {CAP_W{1'b1}}});
        set_idle(14, 14);
        add_random(85);
        drain();

        cfg_write(APB_DW'(0));
        add_random(30);
        drain();

        // back pressure: receiver holds off while the sender keeps offering
        cfg_write(APB_DW'(DEPTH));
        set_idle(0, 0);
        @(posedge i_clk);
        hold_req <= 1'b1;
        add_random(40);
        drain();

        repeat (10) @(posedge i_clk);
        if (failures == 0 && deque_views.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
